// ===== hdl/mmf_pkg.sv =====
// Package for the single-precision matrix product unit.
// Holds field widths, operation and register codes, and the binary32 rounding helpers.
// No dependencies.
package mmf_pkg;

	localparam int MAX_ROWS  = 64;
	localparam int MAX_COLS  = 64;
	localparam int MAX_INNER = 64;

	localparam int OP_W   = 2;
	localparam int IDX_W  = 6;
	localparam int SIZE_W = 7;
	localparam int WORD_W = 32;
	localparam int REG_W  = 2;
	localparam int ADDR_W = 12;

	localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
	localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;
	localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

	localparam logic [REG_W-1:0] REG_ROWS_M  = 2'd0;
	localparam logic [REG_W-1:0] REG_COLS_N  = 2'd1;
	localparam logic [REG_W-1:0] REG_INNER_K = 2'd2;

	localparam logic [WORD_W-1:0] CANON_NAN = 32'h7FC0_0000;
	localparam logic [WORD_W-1:0] POS_ZERO  = 32'h0000_0000;

	typedef logic [WORD_W-1:0] word_t;

	// count leading zeros of a 51-bit value
	function automatic logic [5:0] lzc51(input logic [50:0] v);
		logic [5:0] n;
		logic found;
		n = 6'd0;
		found = 1'b0;
		for (int i = 50; i >= 0; i--) begin
			if (!found) begin
				if (v[i]) found = 1'b1;
				else n = n + 6'd1;
			end
		end
		return n;
	endfunction

	// round a normalized 48-bit significand (bit 47 set) to binary32, nearest even
	function automatic word_t fp_round(input logic sign, input logic signed [11:0] be,
			input logic [47:0] pn, input logic stk);
		logic [5:0]  sh;
		logic [9:0]  be_eff;
		logic [47:0] shifted;
		logic [47:0] mask;
		logic [23:0] m;
		logic        rb;
		logic        sb;
		logic [24:0] mr;
		logic [32:0] tot;
		if (be >= 12'sd1) begin
			sh = 6'd0;
			be_eff = be[9:0] - 10'd1;
		end else if (be < -12'sd46) begin
			sh = 6'd48;
			be_eff = 10'd0;
		end else begin
			sh = 6'(12'sd1 - be);
			be_eff = 10'd0;
		end
		shifted = pn >> sh;
		mask = (48'd1 << sh) - 48'd1;
		m = shifted[47:24];
		rb = shifted[23];
		sb = (|shifted[22:0]) | (|(pn & mask)) | stk;
		mr = {1'b0, m} + {24'd0, rb & (sb | m[0])};
		tot = {be_eff, 23'd0} + {8'd0, mr};
		if (tot[32:23] >= 10'd255) return {sign, 8'hFF, 23'd0};
		return {sign, tot[30:0]};
	endfunction

endpackage

// ===== hdl/mmf_req_if.sv =====
// Request channel of the matrix product unit: valid/ready plus one request item.
// Depends on mmf_pkg.
interface mmf_req_if;
	import mmf_pkg::*;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [IDX_W-1:0]  row_index;
	logic [IDX_W-1:0]  col_index;
	logic [WORD_W-1:0] element_bits;
	modport source(output valid, operation, row_index, col_index, element_bits, input ready);
	modport sink(input valid, operation, row_index, col_index, element_bits, output ready);
endinterface

// ===== hdl/mmf_res_if.sv =====
// Result channel of the matrix product unit: valid/ready plus one result item.
// Depends on mmf_pkg.
interface mmf_res_if;
	import mmf_pkg::*;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] product_bits;
	logic [IDX_W-1:0]  out_row;
	logic [IDX_W-1:0]  out_col;
	logic              status;
	modport source(output valid, product_bits, out_row, out_col, status, input ready);
	modport sink(input valid, product_bits, out_row, out_col, status, output ready);
endinterface

// ===== hdl/mmf_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mmf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== hdl/mmf_fmul.sv =====
// binary32 multiplier: raw significand product registered, then normalize and round.
// Depends on mmf_pkg.
module mmf_fmul (
	input  logic              clk,
	input  mmf_pkg::word_t    a,
	input  mmf_pkg::word_t    b,
	output mmf_pkg::word_t    result
);
	import mmf_pkg::*;

	logic [47:0] p_s1;
	logic [8:0]  esum_s1;
	logic        sign_s1;
	logic        spec_s1;
	word_t       specv_s1;

	logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, s;
	logic [7:0] ea, eb;

	always_comb begin
		a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		a_zero = (a[30:0] == 31'd0);
		b_zero = (b[30:0] == 31'd0);
		s      = a[31] ^ b[31];
		ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
	end

	always_ff @(posedge clk) begin
		p_s1    <= {24'd0, (a[30:23] != 8'd0), a[22:0]} * {24'd0, (b[30:23] != 8'd0), b[22:0]};
		esum_s1 <= {1'b0, ea} + {1'b0, eb};
		sign_s1 <= s;
		spec_s1 <= a_nan || b_nan || a_inf || b_inf || a_zero || b_zero;
		if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) specv_s1 <= CANON_NAN;
		else if (a_inf || b_inf) specv_s1 <= {s, 8'hFF, 23'd0};
		else specv_s1 <= {s, 31'd0};
	end

	logic [5:0]         lz;
	logic [47:0]        pn;
	logic signed [11:0] be;

	always_comb begin
		lz = lzc51({p_s1, 3'b000});
		pn = p_s1 << lz;
		be = $signed({3'b000, esum_s1}) - 12'sd126 - $signed({6'd0, lz});
		result = spec_s1 ? specv_s1 : fp_round(sign_s1, be, pn, 1'b0);
	end
endmodule

// ===== hdl/mmf_fadd.sv =====
// binary32 adder: align and add registered, then normalize and round.
// Depends on mmf_pkg.
module mmf_fadd (
	input  logic           clk,
	input  mmf_pkg::word_t a,
	input  mmf_pkg::word_t b,
	output mmf_pkg::word_t result
);
	import mmf_pkg::*;

	logic [50:0] sum_s1;
	logic [7:0]  el_s1;
	logic        sign_s1;
	logic        zsign_s1;
	logic        spec_s1;
	word_t       specv_s1;

	word_t       lw, sw;
	logic [7:0]  el, es, d;
	logic [23:0] ml, ms;
	logic [49:0] af, bf, bsh;
	logic        st;
	logic        a_nan, b_nan, a_inf, b_inf;
	logic [50:0] sum;

	always_comb begin
		a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		if (b[30:0] > a[30:0]) begin
			lw = b;
			sw = a;
		end else begin
			lw = a;
			sw = b;
		end
		el = (lw[30:23] == 8'd0) ? 8'd1 : lw[30:23];
		es = (sw[30:23] == 8'd0) ? 8'd1 : sw[30:23];
		ml = {(lw[30:23] != 8'd0), lw[22:0]};
		ms = {(sw[30:23] != 8'd0), sw[22:0]};
		d  = el - es;
		af = {ml, 26'd0};
		bf = {ms, 26'd0};
		if (d >= 8'd50) begin
			bsh = 50'd0;
			st  = |ms;
		end else begin
			bsh = bf >> d;
			st  = |(bf & ((50'd1 << d) - 50'd1));
		end
		bsh[0] = bsh[0] | st;
		if (lw[31] == sw[31]) sum = {1'b0, af} + {1'b0, bsh};
		else sum = {1'b0, af} - {1'b0, bsh};
	end

	always_ff @(posedge clk) begin
		sum_s1   <= sum;
		el_s1    <= el;
		sign_s1  <= lw[31];
		zsign_s1 <= a[31] & b[31];
		spec_s1  <= a_nan || b_nan || a_inf || b_inf;
		if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) specv_s1 <= CANON_NAN;
		else if (a_inf) specv_s1 <= a;
		else specv_s1 <= b;
	end

	logic [5:0]         lz;
	logic [50:0]        sn;
	logic signed [11:0] be;

	always_comb begin
		lz = lzc51(sum_s1);
		sn = sum_s1 << lz;
		be = $signed({4'd0, el_s1}) + 12'sd1 - $signed({6'd0, lz});
		if (spec_s1) result = specv_s1;
		else if (sum_s1 == 51'd0) result = {zsign_s1, 31'd0};
		else result = fp_round(sign_s1, be, sn[50:3], |sn[2:0]);
	end
endmodule

// ===== hdl/matrix_multiply_float_unit.sv =====
// Single-precision matrix product unit: element writes into two 4096-word stores, dot products.
// Flow: a taken item is checked; a compute then runs the loop once per inner index before EMIT,
// while writes and flagged items skip the loop; an in-range write frees the input and emits no result.
// Throughput: one item at a time; the next is taken once the unit is back in IDLE after the result
// register loads; the five-step loop (read, two multiply steps, two add steps) per inner index sets the rate.
// Reset (arst_n low, asynchronous) clears sizes, state and output valid; stores stay undefined.
module matrix_multiply_float_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [mmf_pkg::REG_W-1:0]  wr_index,
	input  logic [mmf_pkg::SIZE_W-1:0] wr_data,
	mmf_req_if.sink                    request,
	mmf_res_if.source                  result
);
	import mmf_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_READ = 3'd2;
	localparam logic [2:0] ST_MUL1 = 3'd3;
	localparam logic [2:0] ST_MUL2 = 3'd4;
	localparam logic [2:0] ST_ADD1 = 3'd5;
	localparam logic [2:0] ST_ADD2 = 3'd6;
	localparam logic [2:0] ST_EMIT = 3'd7;

	logic [2:0] state_q;

	// size registers, already saturated at their maxima
	logic [SIZE_W-1:0] em_q, en_q, ek_q;

	// latched request item
	logic [OP_W-1:0]  op_q;
	logic [IDX_W-1:0] row_q, col_q;
	word_t            elem_q;

	logic [SIZE_W-1:0] k_q;
	word_t             acc_q;
	word_t             prod_q;
	logic              err_q;

	logic  out_v_q;
	word_t out_bits_q;
	logic [IDX_W-1:0] out_row_q, out_col_q;
	logic  out_st_q;

	word_t a_rd, b_rd, mul_res, add_res;

	// range checks on the latched item
	logic row_in_m, col_in_k, row_in_k, col_in_n;
	assign row_in_m = {1'b0, row_q} < em_q;
	assign col_in_k = {1'b0, col_q} < ek_q;
	assign row_in_k = {1'b0, row_q} < ek_q;
	assign col_in_n = {1'b0, col_q} < en_q;

	logic we_a, we_b;
	assign we_a = (state_q == ST_EXEC) && (op_q == OP_WRITE_A) && row_in_m && col_in_k;
	assign we_b = (state_q == ST_EXEC) && (op_q == OP_WRITE_B) && row_in_k && col_in_n;

	// A[m][k] sits at m*64+k, B[k][n] at k*64+n
	mmf_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ROWS * MAX_INNER)) u_left_store (
		.clk   (clk),
		.we    (we_a),
		.waddr ({row_q, col_q}),
		.wdata (elem_q),
		.raddr ({row_q, k_q[IDX_W-1:0]}),
		.rdata (a_rd)
	);

	mmf_ram #(.WIDTH(WORD_W), .DEPTH(MAX_INNER * MAX_COLS)) u_right_store (
		.clk   (clk),
		.we    (we_b),
		.waddr ({row_q, col_q}),
		.wdata (elem_q),
		.raddr ({k_q[IDX_W-1:0], col_q}),
		.rdata (b_rd)
	);

	mmf_fmul u_fmul (
		.clk    (clk),
		.a      (a_rd),
		.b      (b_rd),
		.result (mul_res)
	);

	mmf_fadd u_fadd (
		.clk    (clk),
		.a      (acc_q),
		.b      (prod_q),
		.result (add_res)
	);

	assign request.ready = (state_q == ST_IDLE);

	// configuration: saturate each size at its maximum on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_q <= '0;
			en_q <= '0;
			ek_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_ROWS_M:  em_q <= (wr_data > SIZE_W'(MAX_ROWS))  ? SIZE_W'(MAX_ROWS)  : wr_data;
				REG_COLS_N:  en_q <= (wr_data > SIZE_W'(MAX_COLS))  ? SIZE_W'(MAX_COLS)  : wr_data;
				REG_INNER_K: ek_q <= (wr_data > SIZE_W'(MAX_INNER)) ? SIZE_W'(MAX_INNER) : wr_data;
				default: ;
			endcase
		end
	end

	// hold the item on transfer
	always_ff @(posedge clk) begin
		if (request.valid && request.ready) begin
			op_q   <= request.operation;
			row_q  <= request.row_index;
			col_q  <= request.col_index;
			elem_q <= request.element_bits;
		end
	end

	// sequencer: check, then step the inner index through read, multiply and add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			err_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (request.valid) state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					k_q <= '0;
					case (op_q)
						OP_WRITE_A: begin
							err_q   <= 1'b1;
							state_q <= (row_in_m && col_in_k) ? ST_IDLE : ST_EMIT;
						end
						OP_WRITE_B: begin
							err_q   <= 1'b1;
							state_q <= (row_in_k && col_in_n) ? ST_IDLE : ST_EMIT;
						end
						OP_COMPUTE: begin
							err_q <= !(row_in_m && col_in_n);
							if (!(row_in_m && col_in_n) || ek_q == '0) state_q <= ST_EMIT;
							else state_q <= ST_READ;
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_READ: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_ADD1;
				ST_ADD1: state_q <= ST_ADD2;
				ST_ADD2: begin
					k_q     <= k_q + SIZE_W'(1);
					state_q <= (k_q + SIZE_W'(1) == ek_q) ? ST_EMIT : ST_READ;
				end
				ST_EMIT: begin
					if (!out_v_q || result.ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers: product and running sum
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) acc_q <= POS_ZERO;
		else if (state_q == ST_ADD2) acc_q <= add_res;
		if (state_q == ST_MUL2) prod_q <= mul_res;
	end

	// output register: load in EMIT once the slot is free, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (state_q == ST_EMIT && (!out_v_q || result.ready)) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && (!out_v_q || result.ready)) begin
			out_bits_q <= err_q ? POS_ZERO : acc_q;
			out_row_q  <= row_q;
			out_col_q  <= col_q;
			out_st_q   <= err_q;
		end
	end

	assign result.valid        = out_v_q;
	assign result.product_bits = out_bits_q;
	assign result.out_row      = out_row_q;
	assign result.out_col      = out_col_q;
	assign result.status       = out_st_q;
endmodule

// ===== hdl/mmf_checker.sv =====
// Port-level checks for the matrix product unit, bound to its top level.
// Depends on matrix_multiply_float_unit.
module mmf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] product_bits,
	input logic        status
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(product_bits))
		else $error("result dropped or changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> product_bits == 32'd0)
		else $error("flagged result carries nonzero product");

	a_nan_canon: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && product_bits[30:23] == 8'hFF && product_bits[22:0] != 23'd0
		|-> product_bits == 32'h7FC0_0000)
		else $error("non-canonical NaN on output");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in progress");
endmodule

bind matrix_multiply_float_unit mmf_checker u_mmf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (request.valid),
	.in_ready     (request.ready),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.product_bits (result.product_bits),
	.status       (result.status)
);

// ===== verif/tb.sv =====
// Testbench for matrix_multiply_float_unit: element writes and dot-product requests,
// checked against a binary32 product model kept in the bench.
// Depends on mmf_pkg, mmf_req_if, mmf_res_if and the unit itself.
module tb;
	import mmf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [WORD_W-1:0] bits;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic              status;
	} product_t;

	// rows of the directed table: a register write or one request item
	typedef enum logic [1:0] {ROW_CFG, ROW_PREDICT, ROW_NONE, ROW_RESULT} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [REG_W-1:0]  reg_index;
		logic [SIZE_W-1:0] reg_value;
		logic [OP_W-1:0]   op;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [WORD_W-1:0] element;
		product_t          typed;
	} directed_row_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [REG_W-1:0]  wr_index;
	logic [SIZE_W-1:0] wr_data;

	mmf_req_if request();
	mmf_res_if result();

	matrix_multiply_float_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data),
		.request (request.sink),
		.result  (result.source)
	);

	// bench copy of the unit's state
	logic [WORD_W-1:0] left_store  [MAX_ROWS*MAX_INNER];
	logic [WORD_W-1:0] right_store [MAX_INNER*MAX_COLS];
	bit                left_written  [MAX_ROWS*MAX_INNER];
	bit                right_written [MAX_INNER*MAX_COLS];
	int unsigned       size_m, size_n, size_k;

	product_t pending_products[$];
	int       failures;
	longint   cycles;
	bit       no_idle;
	bit       hold_req;
	bit       hold_seen;
	int       hold_left;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// widen a binary32 pattern to binary64, exactly
	function automatic logic [63:0] widen(input logic [31:0] f);
		logic [7:0]  e;
		logic [22:0] m;
		int          p;
		e = f[30:23];
		m = f[22:0];
		if (e == 8'hFF) return {f[31], 11'h7FF, m, 29'd0};
		if (e == 8'd0) begin
			if (m == 23'd0) return {f[31], 63'd0};
			p = 0;
			for (int i = 0; i < 23; i++) if (m[i]) p = i;
			return {f[31], 11'(p + 874), 52'((64'(m) << (52 - p)) & 64'hF_FFFF_FFFF_FFFF)};
		end
		return {f[31], 11'(int'(e) - 127 + 1023), m, 29'd0};
	endfunction

	// round a binary64 pattern to binary32, nearest even; any NaN comes out canonical
	function automatic logic [31:0] narrow(input logic [63:0] d);
		logic [10:0]    e;
		logic [52:0]    sig;
		int             u;
		int             sh;
		longint unsigned kept, rest, half, val;
		e = d[62:52];
		if (e == 11'h7FF) return (d[51:0] != 0) ? CANON_NAN : {d[63], 8'hFF, 23'd0};
		if (e == 11'd0) return {d[63], 31'd0};
		u = int'(e) - 1023;
		if (u > 127) return {d[63], 8'hFF, 23'd0};
		sig = {1'b1, d[51:0]};
		sh = (u >= -126) ? 29 : 29 + (-126 - u);
		if (sh >= 55) return {d[63], 31'd0};
		kept = 64'(sig) >> sh;
		rest = 64'(sig) & ((64'd1 << sh) - 1);
		half = 64'd1 << (sh - 1);
		if (u >= -126) val = (longint'(u + 127) << 23) + (kept & 64'h7F_FFFF);
		else val = kept;
		if (rest > half || (rest == half && kept[0])) val = val + 1;
		if (val >= 64'h7F80_0000) return {d[63], 8'hFF, 23'd0};
		return {d[63], val[30:0]};
	endfunction

	function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
		return narrow($realtobits($bitstoreal(widen(a)) * $bitstoreal(widen(b))));
	endfunction

	function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
		return narrow($realtobits($bitstoreal(widen(a)) + $bitstoreal(widen(b))));
	endfunction

	function automatic int unsigned clip(input int unsigned v, input int unsigned lim);
		return (v > lim) ? lim : v;
	endfunction

	// true when a compute item on (m, n) touches only written entries
	function automatic bit operands_ready(input int m, input int n);
		int em, en, ek;
		em = clip(size_m, MAX_ROWS);
		en = clip(size_n, MAX_COLS);
		ek = clip(size_k, MAX_INNER);
		if (m >= em || n >= en) return 1'b1;
		for (int k = 0; k < ek; k++)
			if (!left_written[m*MAX_INNER+k] || !right_written[k*MAX_COLS+n]) return 1'b0;
		return 1'b1;
	endfunction

	// apply one accepted item to the bench state; returns 1 when a result is due
	function automatic bit model_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic [WORD_W-1:0] e, output product_t p);
		int em, en, ek;
		logic [WORD_W-1:0] acc;
		em = clip(size_m, MAX_ROWS);
		en = clip(size_n, MAX_COLS);
		ek = clip(size_k, MAX_INNER);
		p = '{bits: POS_ZERO, row: r, col: c, status: 1'b1};
		case (op)
			OP_WRITE_A: begin
				if (r >= em || c >= ek) return 1'b1;
				left_store[r*MAX_INNER+c] = e;
				left_written[r*MAX_INNER+c] = 1'b1;
				return 1'b0;
			end
			OP_WRITE_B: begin
				if (r >= ek || c >= en) return 1'b1;
				right_store[r*MAX_COLS+c] = e;
				right_written[r*MAX_COLS+c] = 1'b1;
				return 1'b0;
			end
			OP_COMPUTE: begin
				if (r >= em || c >= en) return 1'b1;
				acc = POS_ZERO;
				for (int k = 0; k < ek; k++)
					acc = fadd(acc, fmul(left_store[r*MAX_INNER+k], right_store[k*MAX_COLS+c]));
				p.bits = acc;
				p.status = 1'b0;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// offer one item, hold it until the transfer, then predict or take the typed result
	task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic [WORD_W-1:0] e,
			input row_kind_t kind, input product_t typed);
		product_t p;
		bit       due;
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 30) begin
			request.valid <= 1'b0;
			@(negedge clk);
		end
		request.valid <= 1'b1;
		request.operation <= op;
		request.row_index <= r;
		request.col_index <= c;
		request.element_bits <= e;
		@(posedge clk);
		while (!request.ready) @(posedge clk);
		due = model_item(op, r, c, e, p);
		if (kind == ROW_RESULT) pending_products.push_back(typed);
		else if (kind == ROW_PREDICT && due) pending_products.push_back(p);
	endtask

	// let every expected product come back, then give the unit time to settle
	task automatic wait_idle();
		@(negedge clk);
		request.valid <= 1'b0;
		while (pending_products.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [REG_W-1:0] idx, input logic [SIZE_W-1:0] v);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= v;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_ROWS_M:  size_m = v;
			REG_COLS_N:  size_n = v;
			REG_INNER_K: size_k = v;
			default: ;
		endcase
	endtask

	task automatic configure(input int m, input int n, input int k);
		wait_idle();
		write_reg(REG_ROWS_M, SIZE_W'(m));
		write_reg(REG_COLS_N, SIZE_W'(n));
		write_reg(REG_INNER_K, SIZE_W'(k));
	endtask

	// mostly moderate values so sums stay finite, plus raw patterns and specials
	function automatic logic [WORD_W-1:0] pick_element();
		logic [WORD_W-1:0] e;
		e = $urandom;
		case ($urandom_range(9))
			0, 1:    return e;
			2:       return {e[31], 8'hFF, 23'd0};
			3:       return {e[31], 31'd0};
			4:       return {e[31], 8'd0, e[22:0]};
			5:       return {e[31], 8'hFF, e[22:0] | 23'd1};
			default: return {e[31], 8'($urandom_range(134, 120)), e[22:0]};
		endcase
	endfunction

	// indices mostly near the configured size, sometimes anywhere
	function automatic logic [IDX_W-1:0] pick_index(input int unsigned size);
		int lim;
		lim = (size >= 63) ? 63 : int'(size);
		if ($urandom_range(9) == 0) return IDX_W'($urandom_range(63));
		return IDX_W'($urandom_range(lim));
	endfunction

	// one random item; a compute on incomplete operands turns into the missing write
	task automatic send_random();
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] r, c;
		int               ek;
		int               sel;
		bit               found;
		sel = $urandom_range(99);
		if (sel < 38) begin
			op = OP_WRITE_A;
			r = pick_index(size_m);
			c = pick_index(size_k);
		end else if (sel < 76) begin
			op = OP_WRITE_B;
			r = pick_index(size_k);
			c = pick_index(size_n);
		end else if (sel < 98) begin
			op = OP_COMPUTE;
			r = pick_index(size_m);
			c = pick_index(size_n);
		end else begin
			op = OP_UNUSED;
			r = IDX_W'($urandom);
			c = IDX_W'($urandom);
		end
		if (op == OP_COMPUTE && !operands_ready(r, c)) begin
			ek = clip(size_k, MAX_INNER);
			found = 1'b0;
			for (int k = 0; k < ek && !found; k++) begin
				if (!left_written[r*MAX_INNER+k]) begin
					op = OP_WRITE_A;
					c = IDX_W'(k);
					found = 1'b1;
				end else if (!right_written[k*MAX_COLS+c]) begin
					op = OP_WRITE_B;
					r = IDX_W'(k);
					found = 1'b1;
				end
			end
		end
		send_item(op, r, c, pick_element(), ROW_PREDICT, '0);
	endtask

	// receiver: random stalls, one long hold-off on request, none while no_idle is set
	always @(negedge clk) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			result.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result.ready <= 1'b0;
		end else begin
			result.ready <= no_idle || ($urandom_range(99) >= 30);
		end
	end

	// compare every transfer on the result channel with the oldest expectation
	always @(posedge clk) begin
		product_t want;
		product_t got;
		if (arst_n && result.valid && result.ready) begin
			got = '{bits: result.product_bits, row: result.out_row, col: result.out_col,
				status: result.status};
			if (pending_products.size() == 0) begin
				$display("%0t: unexpected result bits=%h row=%0d col=%0d status=%0b", $time,
					got.bits, got.row, got.col, got.status);
				failures++;
			end else begin
				want = pending_products.pop_front();
				if (got.bits !== want.bits) begin
					$display("%0t: product_bits expected %h actual %h", $time, want.bits, got.bits);
					failures++;
				end
				if (got.row !== want.row) begin
					$display("%0t: out_row expected %0d actual %0d", $time, want.row, got.row);
					failures++;
				end
				if (got.col !== want.col) begin
					$display("%0t: out_col expected %0d actual %0d", $time, want.col, got.col);
					failures++;
				end
				if (got.status !== want.status) begin
					$display("%0t: status expected %0b actual %0b", $time, want.status,
						got.status);
					failures++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[matrix_multiply_float_unit] ERROR");
			$finish;
		end
	end

	function automatic directed_row_t cfg_row(input logic [REG_W-1:0] idx, input int v);
		return '{kind: ROW_CFG, reg_index: idx, reg_value: SIZE_W'(v), op: '0, row: '0,
			col: '0, element: '0, typed: '0};
	endfunction

	function automatic directed_row_t item_row(input row_kind_t kind, input logic [OP_W-1:0] op,
			input int r, input int c, input logic [WORD_W-1:0] e,
			input logic [WORD_W-1:0] bits, input logic st);
		return '{kind: kind, reg_index: '0, reg_value: '0, op: op, row: IDX_W'(r),
			col: IDX_W'(c), element: e, typed: '{bits: bits, row: IDX_W'(r), col: IDX_W'(c),
			status: st}};
	endfunction

	// sizes and item counts of the random phases; the extremes sit among them
	localparam int PHASES = 8;
	int phase_m     [PHASES] = '{3, 1, 8, 0, 127, 64, 2, 5};
	int phase_n     [PHASES] = '{3, 1, 5, 4, 127, 1, 64, 5};
	int phase_k     [PHASES] = '{3, 1, 6, 4, 127, 3, 64, 1};
	int phase_items [PHASES] = '{150, 60, 200, 40, 200, 120, 150, 130};

	initial begin
		directed_row_t table_rows[$];
		directed_row_t row;
		failures = 0;
		cycles = 0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		hold_seen = 1'b0;
		hold_left = 0;
		size_m = 0;
		size_n = 0;
		size_k = 0;
		foreach (left_written[i]) left_written[i] = 1'b0;
		foreach (right_written[i]) right_written[i] = 1'b0;
		foreach (left_store[i]) left_store[i] = '0;
		foreach (right_store[i]) right_store[i] = '0;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		request.valid = 1'b0;
		request.operation = OP_WRITE_A;
		request.row_index = '0;
		request.col_index = '0;
		request.element_bits = '0;
		result.ready = 1'b0;

		// after reset every size is zero: all items are out of range
		table_rows.push_back(item_row(ROW_RESULT, OP_WRITE_A, 0, 0, 32'h3F80_0000, POS_ZERO, 1));
		table_rows.push_back(item_row(ROW_RESULT, OP_WRITE_B, 63, 63, '1, POS_ZERO, 1));
		table_rows.push_back(item_row(ROW_RESULT, OP_COMPUTE, 0, 0, '0, POS_ZERO, 1));
		table_rows.push_back(item_row(ROW_NONE, OP_UNUSED, 63, 63, '1, '0, 0));
		table_rows.push_back(cfg_row(REG_ROWS_M, 2));
		table_rows.push_back(cfg_row(REG_COLS_N, 2));
		table_rows.push_back(cfg_row(REG_INNER_K, 2));
		// 1*3 + 2*4 = 11
		table_rows.push_back(item_row(ROW_NONE, OP_WRITE_A, 0, 0, 32'h3F80_0000, '0, 0));
		table_rows.push_back(item_row(ROW_NONE, OP_WRITE_A, 0, 1, 32'h4000_0000, '0, 0));
		table_rows.push_back(item_row(ROW_NONE, OP_WRITE_B, 0, 0, 32'h4040_0000, '0, 0));
		table_rows.push_back(item_row(ROW_NONE, OP_WRITE_B, 1, 0, 32'h4080_0000, '0, 0));
		table_rows.push_back(item_row(ROW_RESULT, OP_COMPUTE, 0, 0, '0, 32'h4130_0000, 0));
		// infinity times zero gives the canonical NaN
		table_rows.push_back(item_row(ROW_NONE, OP_WRITE_A, 1, 0, 32'h7F80_0000, '0, 0));
		table_rows.push_back(item_row(ROW_NONE, OP_WRITE_A, 1, 1, 32'h8000_0000, '0, 0));
		table_rows.push_back(item_row(ROW_RESULT, OP_COMPUTE, 1, 0, '0, 32'h7F80_0000, 0));
		table_rows.push_back(item_row(ROW_NONE, OP_WRITE_B, 0, 1, POS_ZERO, '0, 0));
		table_rows.push_back(item_row(ROW_NONE, OP_WRITE_B, 1, 1, 32'h0000_0001, '0, 0));
		table_rows.push_back(item_row(ROW_RESULT, OP_COMPUTE, 1, 1, '0, CANON_NAN, 0));
		table_rows.push_back(item_row(ROW_RESULT, OP_WRITE_A, 2, 0, 32'h1234_5678, POS_ZERO, 1));
		table_rows.push_back(item_row(ROW_RESULT, OP_WRITE_B, 2, 0, 32'h1234_5678, POS_ZERO, 1));
		table_rows.push_back(item_row(ROW_RESULT, OP_COMPUTE, 0, 2, '0, POS_ZERO, 1));
		// empty inner dimension sums to +0
		table_rows.push_back(cfg_row(REG_INNER_K, 0));
		table_rows.push_back(item_row(ROW_RESULT, OP_COMPUTE, 1, 1, '0, POS_ZERO, 0));
		// sizes beyond the maximum saturate, so the far corner is in range
		table_rows.push_back(cfg_row(REG_ROWS_M, 127));
		table_rows.push_back(cfg_row(REG_INNER_K, 127));
		table_rows.push_back(item_row(ROW_NONE, OP_WRITE_A, 63, 63, 32'hFF7F_FFFF, '0, 0));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (table_rows[i]) begin
			row = table_rows[i];
			if (row.kind == ROW_CFG) begin
				wait_idle();
				write_reg(row.reg_index, row.reg_value);
			end else begin
				send_item(row.op, row.row, row.col, row.element, row.kind, row.typed);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			configure(phase_m[ph], phase_n[ph], phase_k[ph]);
			no_idle = (ph == 2);
			for (int i = 0; i < phase_items[ph]; i++) begin
				// hold the result side off while requests keep coming
				if (ph == 0 && i == 20) hold_req = !hold_req;
				// pause the request side until every product is back
				if (ph == 1 && i == 30) wait_idle();
				send_random();
			end
			no_idle = 1'b0;
		end

		wait_idle();
		if (failures == 0) $display("[matrix_multiply_float_unit] OK");
		else $display("[matrix_multiply_float_unit] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/mmf_pkg.sv
hdl/mmf_req_if.sv
hdl/mmf_res_if.sv
hdl/mmf_ram.sv
hdl/mmf_fmul.sv
hdl/mmf_fadd.sv
hdl/matrix_multiply_float_unit.sv
hdl/mmf_checker.sv
verif/tb.sv
